// ===== src/saa_pkg.sv =====
// package: constants, types and codes for the shelf atlas allocator
`timescale 1ns / 1ps
package saa_pkg;
   localparam int MAX_ROWS   = 64;
   localparam int MAX_HOLES  = 64;
   localparam int RIDX_BITS  = $clog2(MAX_ROWS);
   localparam int HIDX_BITS  = $clog2(MAX_HOLES);
   localparam int RCNT_BITS  = $clog2(MAX_ROWS + 1);
   localparam int HCNT_BITS  = $clog2(MAX_HOLES + 1);
   localparam int COORD_BITS = 14;
   localparam logic [COORD_BITS-1:0] MIN_EDGE = 14'd16;
   localparam logic [COORD_BITS-1:0] MAX_EDGE = 14'd8192;

   typedef enum logic [1:0] {
      FUNC_PLACE = 2'd0,
      FUNC_TOUCH = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_PLACED  = 3'd0,
      ST_REJECT  = 3'd1,
      ST_NOROOM  = 3'd2,
      ST_TOUCHED = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   localparam logic [1:0] CSR_INITIAL = 2'd0;
   localparam logic [1:0] CSR_MAX     = 2'd1;
   localparam logic [1:0] CSR_PAD     = 2'd2;

   typedef struct packed {
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] height;
      logic [COORD_BITS-1:0] used;
      logic [31:0]           stamp;
   } row_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] height;
   } hole_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ROW_RD,    // issue row read
      S_ROW_CHK,   // check row data
      S_HOLE_RD,
      S_HOLE_CHK,
      S_HOLE_MV_RD,  // shift holes down after taking one
      S_HOLE_MV_WR,
      S_SHELF,
      S_FAIL,
      S_LRU_RD,
      S_LRU_CHK,
      S_EVICT_RD,
      S_EVICT_HOLE,
      S_ROW_MV_RD,
      S_ROW_MV_WR,
      S_COMMIT,
      S_TOUCH_RD,
      S_TOUCH_CHK,
      S_DONE
   } state_type;

   function automatic logic [COORD_BITS-1:0] clamp_edge(input logic [COORD_BITS-1:0] v,
                                                        input logic [COORD_BITS-1:0] lo);
      if (v < lo) return lo;
      if (v > MAX_EDGE) return MAX_EDGE;
      return v;
   endfunction
endpackage

// ===== src/saa_ram.sv =====
// generic single-port synchronous ram with registered read
`timescale 1ns / 1ps
module saa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== src/shelf_atlas_allocator.sv =====
// top level: shelf allocator sequencer over row and hole memories
`timescale 1ns / 1ps
// Shelf allocator for a square texture atlas. Rows and free holes live in two
// single-port memories of 64 entries; one sequencer walks them, with a read
// state and a check state for each entry. A place request tries the rows, then
// the holes, then the shelf; if all fail, the worst case runs a pass after
// growth, an LRU scan, an eviction shift of the row table and a final pass.
// Touch scans the rows for a matching y, and clear or a rejected request goes
// straight to done. One request is in work at a time;
// the result is held in an output register until taken, and req_stall is
// high while busy or while a result waits.
module shelf_atlas_allocator
   import saa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_func,
   input  logic [13:0]           req_glyph_width,
   input  logic [13:0]           req_glyph_height,
   input  logic [12:0]           req_row_y,
   input  logic [31:0]           req_tick,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [12:0]           rsp_slot_x,
   output logic [12:0]           rsp_slot_y,
   output logic                  rsp_grew,
   output logic [13:0]           rsp_current_size,
   output logic                  rsp_evicted,
   output logic [12:0]           rsp_evicted_y,
   output logic [13:0]           rsp_evicted_height,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [13:0]           csr_data
);
   logic [13:0] init_ff, maxr_ff;
   logic [7:0]  pad_ff;
   logic [13:0] size_ff, size_in, shelf_ff, shelf_in;
   logic [RCNT_BITS-1:0] rcnt_ff, rcnt_in;
   logic [HCNT_BITS-1:0] hcnt_ff, hcnt_in;
   state_type st_ff, st_in;

   // request latch
   logic [13:0] w_ff, h_ff;
   logic [12:0] ry_ff;
   logic [31:0] tick_ff;

   logic [RCNT_BITS-1:0] ri_ff, ri_in;   // row index
   logic [HCNT_BITS-1:0] hi_ff, hi_in;   // hole index
   logic [1:0]  pass_ff, pass_in;        // 0 first try, 1 after growth, 2 after eviction
   logic        grew_ff, grew_in, ev_ff, ev_in;
   logic [13:0] ey_ff, ey_in, eh_ff, eh_in;
   logic [RIDX_BITS-1:0] lru_ff, lru_in;
   logic [31:0] lrut_ff, lrut_in;
   logic [RIDX_BITS-1:0] hit_ff, hit_in;  // row that takes the glyph
   row_type     hitrow_ff, hitrow_in;
   hole_type    tmph_ff, tmph_in;

   logic [2:0]  ost_ff, ost_in;
   logic [13:0] osx_ff, osx_in, osy_ff, osy_in;
   logic        ovld_ff;

   // memory ports
   logic                 rwe, hwe;
   logic [RIDX_BITS-1:0] raddr;
   logic [HIDX_BITS-1:0] haddr;
   row_type              rwd, rrd;
   hole_type             hwd, hrd;

   saa_ram #(.WIDTH($bits(row_type)), .DEPTH(MAX_ROWS)) u_rows (
      .clock(clock), .wr_en(rwe), .addr(raddr), .wr_data(rwd), .rd_data(rrd));
   saa_ram #(.WIDTH($bits(hole_type)), .DEPTH(MAX_HOLES)) u_holes (
      .clock(clock), .wr_en(hwe), .addr(haddr), .wr_data(hwd), .rd_data(hrd));

   logic idle, accept, csr_fire;
   logic [13:0] init_edge, eff_max;
   logic [14:0] fit_row, fit_shelf;
   logic [14:0] dbl;
   logic bad_req, row_fit, hole_fit, shelf_fit, grow_ok, evict_ok;
   logic hmv_last, rmv_last, ry_match;

   assign idle      = (st_ff == S_IDLE);
   assign req_stall = !idle || ovld_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = idle && !ovld_ff;
   assign csr_fire  = csr_valid && csr_ready;
   assign init_edge = clamp_edge(init_ff, MIN_EDGE);
   assign eff_max   = clamp_edge(maxr_ff, init_edge);
   assign fit_row   = {1'b0, rrd.used} + {1'b0, w_ff} + {7'd0, pad_ff};
   assign fit_shelf = {1'b0, shelf_ff} + {1'b0, h_ff} + {7'd0, pad_ff};
   assign dbl       = {size_ff, 1'b0};

   assign bad_req   = req_glyph_width == '0 || req_glyph_height == '0 ||
                      req_glyph_width > size_ff || req_glyph_height > size_ff;
   assign row_fit   = rrd.height >= h_ff && fit_row <= {1'b0, size_ff};
   assign hole_fit  = hrd.height >= h_ff;
   assign shelf_fit = fit_shelf <= {1'b0, size_ff};
   assign grow_ok   = pass_ff == 2'd0 && size_ff < eff_max;
   assign evict_ok  = pass_ff != 2'd2 && rcnt_ff != '0 && hcnt_ff < HCNT_BITS'(MAX_HOLES);
   assign hmv_last  = (hi_ff + 1'b1) >= hcnt_ff;
   assign rmv_last  = (ri_ff + 1'b1) >= rcnt_ff;
   assign ry_match  = rrd.y == {1'b0, ry_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         ovld_ff <= 1'b0;
         init_ff <= 14'd1024;
         maxr_ff <= 14'd8192;
         pad_ff  <= 8'd1;
         size_ff <= 14'd1024;
         shelf_ff <= '0;
         rcnt_ff <= '0;
         hcnt_ff <= '0;
      end else begin
         st_ff    <= st_in;
         size_ff  <= size_in;
         shelf_ff <= shelf_in;
         rcnt_ff  <= rcnt_in;
         hcnt_ff  <= hcnt_in;
         if (st_ff == S_DONE) begin
            ovld_ff <= 1'b1;
         end else if (ovld_ff && !rsp_stall) begin
            ovld_ff <= 1'b0;
         end
         if (csr_fire) begin
            unique case (csr_index)
               CSR_INITIAL: init_ff <= csr_data;
               CSR_MAX: maxr_ff <= csr_data;
               CSR_PAD: pad_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         w_ff    <= req_glyph_width;
         h_ff    <= req_glyph_height;
         ry_ff   <= req_row_y;
         tick_ff <= req_tick;
      end
      ri_ff <= ri_in; hi_ff <= hi_in; pass_ff <= pass_in;
      grew_ff <= grew_in; ev_ff <= ev_in; ey_ff <= ey_in; eh_ff <= eh_in;
      lru_ff <= lru_in; lrut_ff <= lrut_in; hit_ff <= hit_in;
      hitrow_ff <= hitrow_in; tmph_ff <= tmph_in;
      ost_ff <= ost_in; osx_ff <= osx_in; osy_ff <= osy_in;
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (accept) begin
               case (func_type'(req_func))
                  FUNC_PLACE: st_in = bad_req ? S_DONE : S_ROW_RD;
                  FUNC_TOUCH: st_in = S_TOUCH_RD;
                  default:    st_in = S_DONE;
               endcase
            end
         end
         S_ROW_RD: begin
            if (ri_ff >= rcnt_ff) begin
               st_in = (rcnt_ff >= RCNT_BITS'(MAX_ROWS)) ? S_FAIL : S_HOLE_RD;
            end else begin
               st_in = S_ROW_CHK;
            end
         end
         S_ROW_CHK:    st_in = row_fit ? S_COMMIT : S_ROW_RD;
         S_HOLE_RD:    st_in = (hi_ff >= hcnt_ff) ? S_SHELF : S_HOLE_CHK;
         S_HOLE_CHK:   st_in = hole_fit ? S_HOLE_MV_RD : S_HOLE_RD;
         S_HOLE_MV_RD: st_in = hmv_last ? S_COMMIT : S_HOLE_MV_WR;
         S_HOLE_MV_WR: st_in = S_HOLE_MV_RD;
         S_SHELF:      st_in = shelf_fit ? S_COMMIT : S_FAIL;
         S_FAIL: begin
            if (grow_ok) begin
               st_in = S_ROW_RD;
            end else if (evict_ok) begin
               st_in = S_LRU_RD;
            end else begin
               st_in = S_DONE;
            end
         end
         S_LRU_RD:     st_in = (ri_ff >= rcnt_ff) ? S_EVICT_RD : S_LRU_CHK;
         S_LRU_CHK:    st_in = S_LRU_RD;
         S_EVICT_RD:   st_in = S_EVICT_HOLE;
         S_EVICT_HOLE: st_in = S_ROW_MV_RD;
         S_ROW_MV_RD:  st_in = rmv_last ? S_ROW_RD : S_ROW_MV_WR;
         S_ROW_MV_WR:  st_in = S_ROW_MV_RD;
         S_COMMIT:     st_in = S_DONE;
         S_TOUCH_RD:   st_in = (ri_ff >= rcnt_ff) ? S_DONE : S_TOUCH_CHK;
         S_TOUCH_CHK:  st_in = ry_match ? S_DONE : S_TOUCH_RD;
         S_DONE:       st_in = S_IDLE;
         default:      st_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      size_in = size_ff; shelf_in = shelf_ff; rcnt_in = rcnt_ff; hcnt_in = hcnt_ff;
      ri_in = ri_ff; hi_in = hi_ff; pass_in = pass_ff;
      grew_in = grew_ff; ev_in = ev_ff; ey_in = ey_ff; eh_in = eh_ff;
      lru_in = lru_ff; lrut_in = lrut_ff; hit_in = hit_ff;
      hitrow_in = hitrow_ff; tmph_in = tmph_ff;
      ost_in = ost_ff; osx_in = osx_ff; osy_in = osy_ff;
      rwe = 1'b0; hwe = 1'b0;
      raddr = ri_ff[RIDX_BITS-1:0];
      haddr = hi_ff[HIDX_BITS-1:0];
      rwd = rrd; hwd = hrd;
      unique case (st_ff)
         S_IDLE: begin
            if (accept) begin
               ri_in = '0; hi_in = '0; pass_in = '0;
               grew_in = 1'b0; ev_in = 1'b0; ey_in = '0; eh_in = '0;
               osx_in = '0; osy_in = '0;
               case (func_type'(req_func))
                  FUNC_PLACE: begin
                     if (bad_req) begin
                        ost_in = ST_REJECT;
                     end
                  end
                  FUNC_TOUCH: ost_in = ST_TOUCHED;
                  FUNC_CLEAR: begin
                     rcnt_in = '0; hcnt_in = '0; shelf_in = '0;
                     ost_in = ST_CLEARED;
                  end
                  default: ost_in = ST_REJECT;
               endcase
            end
         end
         S_ROW_RD: begin
            if (ri_ff >= rcnt_ff) begin
               hi_in = '0;
            end
         end
         S_ROW_CHK: begin
            if (row_fit) begin
               hit_in = ri_ff[RIDX_BITS-1:0];
               hitrow_in = rrd;
               hitrow_in.stamp = tick_ff;
            end else begin
               ri_in = ri_ff + 1'b1;
            end
         end
         S_HOLE_CHK: begin
            if (hole_fit) begin
               hit_in = rcnt_ff[RIDX_BITS-1:0];
               hitrow_in = '{y: hrd.y, height: hrd.height, used: '0, stamp: tick_ff};
               rcnt_in = rcnt_ff + 1'b1;
            end else begin
               hi_in = hi_ff + 1'b1;
            end
         end
         S_HOLE_MV_RD: begin
            // read entry hi+1 to close the gap
            if (hmv_last) begin
               hcnt_in = hcnt_ff - 1'b1;
            end else begin
               haddr = HIDX_BITS'(hi_ff + 1'b1);
            end
         end
         S_HOLE_MV_WR: begin
            hwe = 1'b1; hwd = hrd;
            hi_in = hi_ff + 1'b1;
         end
         S_SHELF: begin
            if (shelf_fit) begin
               hit_in = rcnt_ff[RIDX_BITS-1:0];
               hitrow_in = '{y: shelf_ff, height: h_ff, used: '0, stamp: tick_ff};
               shelf_in = fit_shelf[13:0];
               rcnt_in = rcnt_ff + 1'b1;
            end
         end
         S_FAIL: begin
            ri_in = '0;
            if (grow_ok) begin
               size_in = (dbl > {1'b0, eff_max}) ? eff_max : dbl[13:0];
               grew_in = 1'b1; pass_in = 2'd1;
            end else if (evict_ok) begin
               lru_in = '0;
            end else begin
               ost_in = ST_NOROOM;
            end
         end
         S_LRU_CHK: begin
            if (ri_ff == '0 || rrd.stamp < lrut_ff) begin
               lru_in = ri_ff[RIDX_BITS-1:0]; lrut_in = rrd.stamp;
            end
            ri_in = ri_ff + 1'b1;
         end
         S_EVICT_RD: begin
            raddr = lru_ff;
         end
         S_EVICT_HOLE: begin
            ev_in = 1'b1; ey_in = rrd.y; eh_in = rrd.height;
            haddr = hcnt_ff[HIDX_BITS-1:0];
            hwe = 1'b1; hwd = '{y: rrd.y, height: rrd.height};
            hcnt_in = hcnt_ff + 1'b1;
            ri_in = RCNT_BITS'(lru_ff);
         end
         S_ROW_MV_RD: begin
            if (rmv_last) begin
               rcnt_in = rcnt_ff - 1'b1;
               ri_in = '0; pass_in = 2'd2;
            end else begin
               raddr = RIDX_BITS'(ri_ff + 1'b1);
            end
         end
         S_ROW_MV_WR: begin
            rwe = 1'b1; rwd = rrd;
            ri_in = ri_ff + 1'b1;
         end
         S_COMMIT: begin
            raddr = hit_ff;
            rwe = 1'b1;
            rwd = hitrow_ff;
            rwd.used = hitrow_ff.used + w_ff + {6'd0, pad_ff};
            osx_in = hitrow_ff.used; osy_in = hitrow_ff.y;
            ost_in = ST_PLACED;
         end
         S_TOUCH_CHK: begin
            if (ry_match) begin
               rwe = 1'b1; rwd = rrd; rwd.stamp = tick_ff;
            end else begin
               ri_in = ri_ff + 1'b1;
            end
         end
         default: ;
      endcase
      // writing the initial size restarts the atlas empty
      if (csr_fire && csr_index == CSR_INITIAL) begin
         size_in  = clamp_edge(csr_data, MIN_EDGE);
         shelf_in = '0;
         rcnt_in  = '0;
         hcnt_in  = '0;
      end
   end

   assign rsp_valid          = ovld_ff;
   assign rsp_status         = ost_ff;
   assign rsp_slot_x         = osx_ff[12:0];
   assign rsp_slot_y         = osy_ff[12:0];
   assign rsp_grew           = grew_ff;
   assign rsp_current_size   = size_ff;
   assign rsp_evicted        = ev_ff;
   assign rsp_evicted_y      = ey_ff[12:0];
   assign rsp_evicted_height = eh_ff;

`ifndef ASSERT_OFF
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      !idle |-> req_stall) else $error("request taken while busy");
   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= RCNT_BITS'(MAX_ROWS)) else $error("row count overflow");
   a_holes_bound: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= HCNT_BITS'(MAX_HOLES)) else $error("hole count overflow");
   a_size_range: assert property (@(posedge clock) disable iff (reset)
      size_ff >= MIN_EDGE && size_ff <= MAX_EDGE) else $error("atlas size out of range");
`endif
endmodule
